// File: rtl/crc16_frame_checker_unit_assert.svh
// assertion macros for the crc16 frame checker
`ifndef CRC16_FRAME_CHECKER_UNIT_ASSERT_SVH
`define CRC16_FRAME_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, quiet while in reset
`define C16FC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crc16 frame checker: same-cycle check failed");

// next-cycle implication, clocked on clk, quiet while in reset
`define C16FC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crc16 frame checker: next-cycle check failed");

`endif

// File: rtl/crc16fc_pkg.sv
package crc16fc_pkg;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // byte position counts bytes seen, saturating
  localparam logic [2:0] POS_MAX       = 3'd7;
  localparam logic [2:0] POS_SYNC      = 3'd0;
  localparam logic [2:0] POS_ADDR_HI   = 3'd1;
  localparam logic [2:0] POS_ADDR_LO   = 3'd2;
  localparam logic [2:0] POS_OPERATION = 3'd3;
  localparam logic [2:0] POS_DATA_ADDR = 3'd4;
  // a frame ending at this position or beyond is long enough
  localparam logic [2:0] POS_MIN_LAST  = 3'd6;

  localparam logic [7:0] SYNC_RESET    = 8'h55;
  localparam logic [7:0] ADDR_HI_RESET = 8'hFE;
  localparam logic [7:0] ADDR_LO_RESET = 8'hFE;

  typedef enum logic [1:0] {
    REG_SYNC    = 2'd0,
    REG_ADDR_HI = 2'd1,
    REG_ADDR_LO = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_SHORT   = 2'd1,
    ST_BAD_HDR = 2'd2,
    ST_BAD_CRC = 2'd3
  } frame_status_t;

  typedef struct packed {
    logic [7:0] sync_byte;
    logic [7:0] address_first;
    logic [7:0] address_second;
  } cfg_t;

endpackage

// File: rtl/crc16_frame_checker_unit.sv
// crc16 frame checker: takes a received serial frame one byte per beat on the
// in_ channel, with in_end_of_frame high on the final byte, and gives one
// result beat per frame on the out_ channel (status, operation byte, data
// address byte). a reflected crc-16 (poly 0xA001, start 0xFFFF) runs over all
// bytes except the trailing two, which carry the crc low byte first. status
// is good, too short (under seven bytes), bad header (sync and two address
// bytes against the cfg_ registers at 0x0, 0x4, 0x8) or bad crc, in that
// priority. throughput is one byte per clock: each byte passes through one
// unrolled eight-bit crc update and a 16-bit compare between the frame state
// registers and the result register, and a result waiting in the output
// register does not stop the next byte when out_ready is high in that cycle.
module crc16_frame_checker_unit (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_frame,
  // frame result
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_frame_status,
  output logic [7:0]  out_operation_code,
  output logic [7:0]  out_register_address,
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import crc16fc_pkg::*;

  cfg_t cfg;

  // per-frame state
  logic [15:0] crc_r;
  logic [7:0]  older_r;
  logic [7:0]  newer_r;
  logic [2:0]  pos_r;
  logic        hdr_ok_r;
  logic [7:0]  held_op_r;
  logic [7:0]  held_addr_r;

  // result register
  logic        out_valid_r;
  logic [1:0]  status_r;
  logic [7:0]  op_r;
  logic [7:0]  addr_r;

  logic          accept;
  logic [15:0]   crc_fed;
  logic [15:0]   crc_cur;
  logic          hdr_ok_cur;
  logic [7:0]    op_cur;
  logic [7:0]    addr_cur;
  frame_status_t status_nxt;

  crc16fc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // the byte leaving the delay pair is never one of the trailing crc bytes
  crc16fc_crc_byte u_crc (
    .crc_in  (crc_r),
    .data_in (older_r),
    .crc_out (crc_fed)
  );

  // output register frees up when its beat is taken in the same cycle
  assign in_ready = ~out_valid_r | out_ready;
  assign accept   = in_valid & in_ready;

  assign crc_cur = (pos_r >= POS_ADDR_LO) ? crc_fed : crc_r;

  // header compare against live register values
  always_comb begin
    hdr_ok_cur = hdr_ok_r;
    if (pos_r == POS_SYNC && in_data_byte != cfg.sync_byte) begin
      hdr_ok_cur = 1'b0;
    end
    if (pos_r == POS_ADDR_HI && in_data_byte != cfg.address_first) begin
      hdr_ok_cur = 1'b0;
    end
    if (pos_r == POS_ADDR_LO && in_data_byte != cfg.address_second) begin
      hdr_ok_cur = 1'b0;
    end
  end

  assign op_cur   = (pos_r == POS_OPERATION) ? in_data_byte : held_op_r;
  assign addr_cur = (pos_r == POS_DATA_ADDR) ? in_data_byte : held_addr_r;

  // status priority: short, then header, then crc
  // trailing pair is crc low then high, so high byte is the current one
  always_comb begin
    if (pos_r < POS_MIN_LAST) begin
      status_nxt = ST_SHORT;
    end else if (!hdr_ok_cur) begin
      status_nxt = ST_BAD_HDR;
    end else if (crc_cur != {in_data_byte, newer_r}) begin
      status_nxt = ST_BAD_CRC;
    end else begin
      status_nxt = ST_GOOD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_INIT;
      older_r     <= 8'd0;
      newer_r     <= 8'd0;
      pos_r       <= 3'd0;
      hdr_ok_r    <= 1'b1;
      held_op_r   <= 8'd0;
      held_addr_r <= 8'd0;
    end else if (accept) begin
      if (in_end_of_frame) begin
        // back to a clean frame
        crc_r       <= CRC_INIT;
        older_r     <= 8'd0;
        newer_r     <= 8'd0;
        pos_r       <= 3'd0;
        hdr_ok_r    <= 1'b1;
        held_op_r   <= 8'd0;
        held_addr_r <= 8'd0;
      end else begin
        crc_r       <= crc_cur;
        older_r     <= newer_r;
        newer_r     <= in_data_byte;
        hdr_ok_r    <= hdr_ok_cur;
        held_op_r   <= op_cur;
        held_addr_r <= addr_cur;
        if (pos_r != POS_MAX) begin
          pos_r <= pos_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && in_end_of_frame) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept && in_end_of_frame) begin
      status_r <= status_nxt;
      op_r     <= op_cur;
      addr_r   <= addr_cur;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_frame_status     = status_r;
  assign out_operation_code   = op_r;
  assign out_register_address = addr_r;

`include "crc16_frame_checker_unit_assert.svh"

  // last byte always leaves a result and a cleared frame
  `C16FC_ASSERT_NEXT(a_eof_result, accept && in_end_of_frame, out_valid_r && pos_r == 3'd0 && crc_r == CRC_INIT)
  // a byte ending before the seventh is always reported short
  `C16FC_ASSERT_NEXT(a_short_frame, accept && in_end_of_frame && pos_r < POS_MIN_LAST, status_r == ST_SHORT)
  // position steps by one on every mid-frame byte until it saturates
  `C16FC_ASSERT_NEXT(a_pos_step, accept && !in_end_of_frame && pos_r != POS_MAX, pos_r == $past(pos_r) + 3'd1)
  // header flag never recovers inside a frame
  `C16FC_ASSERT_NEXT(a_hdr_sticky, accept && !in_end_of_frame && !hdr_ok_r, !hdr_ok_r)

endmodule

// File: rtl/crc16fc_crc_byte.sv
module crc16fc_crc_byte (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);
  import crc16fc_pkg::*;

  // reflected crc, eight bit steps unrolled
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data_in};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

// File: rtl/crc16fc_cfg_regs.sv
module crc16fc_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready,
  output crc16fc_pkg::cfg_t   cfg
);
  import crc16fc_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] idx;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[3:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_byte      <= SYNC_RESET;
      cfg_r.address_first  <= ADDR_HI_RESET;
      cfg_r.address_second <= ADDR_LO_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_SYNC:    cfg_r.sync_byte      <= cfg_pwdata[7:0];
        REG_ADDR_HI: cfg_r.address_first  <= cfg_pwdata[7:0];
        REG_ADDR_LO: cfg_r.address_second <= cfg_pwdata[7:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SYNC:    cfg_prdata = {24'd0, cfg_r.sync_byte};
      REG_ADDR_HI: cfg_prdata = {24'd0, cfg_r.address_first};
      REG_ADDR_LO: cfg_prdata = {24'd0, cfg_r.address_second};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule
